>>> hdl/sfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constant-table builders for the square-wave Fourier
// synthesizer. No dependencies.
package sfs_pkg;

  localparam int unsigned MaxHarmonicsDef  = 64;
  localparam int unsigned SineTableBitsDef = 10;

  localparam int unsigned AmpW    = 16;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned LimW    = 7;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SampleW = 24;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned QsineW  = 16;
  localparam int unsigned SineW   = 17;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 2 * MulW;

  localparam logic [AmpW-1:0]  AmpRst   = AmpW'(256);
  localparam logic [FreqW-1:0] FreqRst  = FreqW'(65536);
  localparam logic [LimW-1:0]  LimitRst = LimW'(8);

  localparam longint unsigned HalfPiQ30    = 64'd1686629713;
  localparam longint unsigned TwoOverPiQ32 = 64'd2734261102;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAmplitude = 2'd0,
    CfgFrequency = 2'd1,
    CfgLimit     = 2'd2
  } cfg_idx_e;

  // sin(pi/2 * q / quarter) with 15 fraction bits, Taylor terms up to x^11
  function automatic logic [QsineW-1:0] sfs_quarter_sine(input int unsigned q,
                                                          input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = (HalfPiQ30 * 64'(q) + (64'd1 << (tbits - 3))) >> (tbits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    rnd = (unsigned'(sum) + 64'd16384) >> 15;
    return rnd[QsineW-1:0];
  endfunction

endpackage

>>> hdl/sfs_in_if.sv
`timescale 1ns / 1ps
// Input channel of the synthesizer: one time value per beat.
// Depends on sfs_pkg.
interface sfs_in_if import sfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] time_value;

  modport source (output valid, output time_value, input ready);
  modport sink   (input valid, input time_value, output ready);
endinterface

>>> hdl/sfs_out_if.sv
`timescale 1ns / 1ps
// Output channel of the synthesizer: one saturated sample per beat.
// Depends on sfs_pkg.
interface sfs_out_if import sfs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/square_wave_fourier_synth_unit.sv
`timescale 1ns / 1ps
// Square-wave Fourier synthesizer top level: sequencer, phase stepper, ROMs,
// accumulator and output register. Depends on sfs_pkg, sfs_in_if, sfs_out_if, sfs_mul.
//
// One time value in, one sample out. A single 33x33 multiplier is shared: it forms
// the fractional cycle f*t, then one coefficient-times-sine product per odd harmonic
// (one issued per cycle through a three-deep ROM/multiply/accumulate pipe), then the
// final scaling by the amplitude. With L = min(harmonic_limit, MaxHarmonics), an item
// sums the odd harmonics below L (none when L is below 2), and the block is ready for
// the next item once its sample is in the output register. The input is not ready
// while an item is in flight; a finished sample waits in the output register, and the
// block takes the next time value while it waits. Registers must be written only while
// the block is idle; the block itself does not enforce this.
module square_wave_fourier_synth_unit import sfs_pkg::*; #(
  parameter int unsigned MaxHarmonics  = MaxHarmonicsDef,
  parameter int unsigned SineTableBits = SineTableBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  sfs_in_if.sink               in_i,
  sfs_out_if.source            out_o
);

  localparam int unsigned Quarter = 1 << (SineTableBits - 2);
  localparam int unsigned AddrW   = SineTableBits - 1;
  localparam int unsigned NIdxW   = (MaxHarmonics > 1) ? $clog2(MaxHarmonics) : 1;
  localparam int unsigned NW      = $clog2(MaxHarmonics + 2);
  localparam int unsigned CmpW    = NW + LimW;
  localparam int unsigned AccW    = CoefW + SineW + $clog2(MaxHarmonics);

  localparam logic signed [AccW-1:0]  AccRound  = AccW'(64'd1 << 22);
  localparam logic signed [MulW-1:0]  HalfOne   = MulW'(64'd1 << 23);
  localparam logic signed [ProdW-1:0] ProdRound = ProdW'(64'd1 << 23);
  localparam logic signed [ProdW-1:0] SatMax    = ProdW'(64'd8388607);
  localparam logic signed [ProdW-1:0] SatMin    = -SatMax - ProdW'(64'd1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMulF  = 7'b0000010,
    StLoadF = 7'b0000100,
    StHarm  = 7'b0001000,
    StSum   = 7'b0010000,
    StScale = 7'b0100000,
    StRound = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [AmpW-1:0]   amp_q;
  logic [FreqW-1:0]  freq_q;
  logic [LimW-1:0]   limit_q;
  logic [TimeW-1:0]  time_q;
  logic [PhaseW-1:0] frac_q;
  logic [PhaseW-1:0] phase_q;
  logic [NW-1:0]     n_q;

  logic                    v1_q;
  logic                    v2_q;
  logic signed [SineW-1:0] sine_q;
  logic [CoefW-1:0]        coef_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [MulW-1:0]  sum24_q;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_q;

  // constant tables
  logic [QsineW-1:0] qsine_w [Quarter+1];
  logic [CoefW-1:0]  coef_w  [MaxHarmonics];

  for (genvar g = 0; g <= Quarter; g++) begin : g_qsine
    assign qsine_w[g] = sfs_quarter_sine(g, SineTableBits);
  end

  for (genvar g = 0; g < MaxHarmonics; g++) begin : g_coef
    localparam longint unsigned Num  = (g == 0) ? 64'd1 : 64'(g);
    localparam logic [CoefW-1:0] Coef =
      (g == 0) ? '0 : CoefW'((TwoOverPiQ32 + Num / 2) / Num);
    assign coef_w[g] = Coef;
  end

  // harmonic issue and sine lookup
  logic                     issue_w;
  logic [SineTableBits-1:0] idx_w;
  logic [1:0]               quad_w;
  logic [AddrW-1:0]         rem_w;
  logic [AddrW-1:0]         addr_w;
  logic [SineW-1:0]         mag_w;

  assign issue_w = (state_q == StHarm)
                && (CmpW'(n_q) < CmpW'(limit_q))
                && (CmpW'(n_q) < CmpW'(MaxHarmonics));
  assign idx_w   = phase_q[PhaseW-1 -: SineTableBits];
  assign quad_w  = idx_w[SineTableBits-1 -: 2];
  assign rem_w   = AddrW'(idx_w[SineTableBits-3:0]);
  assign addr_w  = quad_w[0] ? (AddrW'(Quarter) - rem_w) : rem_w;
  assign mag_w   = SineW'(qsine_w[addr_w]);

  // shared multiplier
  logic signed [MulW-1:0]  mul_a_w;
  logic signed [MulW-1:0]  mul_b_w;
  logic signed [ProdW-1:0] prod_w;

  always_comb begin
    mul_a_w = '0;
    mul_b_w = '0;
    unique case (state_q)
      StMulF: begin
        mul_a_w = signed'(MulW'(freq_q));
        mul_b_w = signed'(MulW'(time_q));
      end
      StHarm: begin
        mul_a_w = signed'(MulW'(coef_q));
        mul_b_w = MulW'(sine_q);
      end
      StScale, StRound: begin
        mul_a_w = signed'(MulW'(amp_q));
        mul_b_w = sum24_q;
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase
  end

  sfs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a_w),
    .b_i    (mul_b_w),
    .prod_o (prod_w)
  );

  // rounding and saturation
  logic signed [AccW-1:0]  acc_rnd_w;
  logic signed [AccW-1:0]  acc_shr_w;
  logic signed [ProdW-1:0] tot_rnd_w;
  logic signed [ProdW-1:0] tot_shr_w;
  logic signed [SampleW-1:0] sample_w;

  assign acc_rnd_w = acc_q + AccRound;
  assign acc_shr_w = acc_rnd_w >>> 23;
  assign tot_rnd_w = prod_w + ProdRound;
  assign tot_shr_w = tot_rnd_w >>> 24;

  always_comb begin
    if (tot_shr_w > SatMax) begin
      sample_w = SampleW'(SatMax);
    end else if (tot_shr_w < SatMin) begin
      sample_w = SampleW'(SatMin);
    end else begin
      sample_w = tot_shr_w[SampleW-1:0];
    end
  end

  logic out_free_w;
  assign out_free_w = !out_valid_q || out_o.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_i.valid) state_d = StMulF;
      StMulF:  state_d = StLoadF;
      StLoadF: state_d = StHarm;
      StHarm:  if (!issue_w && !v1_q) state_d = StSum;
      StSum:   state_d = StScale;
      StScale: state_d = StRound;
      StRound: if (out_free_w) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      amp_q       <= AmpRst;
      freq_q      <= FreqRst;
      limit_q     <= LimitRst;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue_w;
      v2_q    <= v1_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgAmplitude: amp_q   <= cfg_wdata_i[AmpW-1:0];
          CfgFrequency: freq_q  <= cfg_wdata_i[FreqW-1:0];
          CfgLimit:     limit_q <= cfg_wdata_i[LimW-1:0];
          default: ;
        endcase
      end
      if (state_q == StRound && out_free_w) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_i.valid) begin
      time_q <= in_i.time_value;
    end
    if (state_q == StLoadF) begin
      frac_q  <= prod_w[PhaseW-1:0];
      phase_q <= prod_w[PhaseW-1:0];
      n_q     <= NW'(1);
      acc_q   <= '0;
    end else begin
      if (issue_w) begin
        phase_q <= phase_q + (frac_q << 1);
        n_q     <= n_q + NW'(2);
      end
      if (v2_q) begin
        acc_q <= acc_q + signed'(prod_w[AccW-1:0]);
      end
    end
    if (issue_w) begin
      sine_q <= quad_w[1] ? -signed'(mag_w) : signed'(mag_w);
      coef_q <= coef_w[n_q[NIdxW-1:0]];
    end
    if (state_q == StSum) begin
      sum24_q <= signed'(acc_shr_w[MulW-1:0]) + HalfOne;
    end
    if (state_q == StRound && out_free_w) begin
      sample_q <= sample_w;
    end
  end

  assign in_i.ready   = (state_q == StIdle);
  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

  // checks
  a_out_from_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StRound))
    else $error("sample presented without a finished sum");

  a_odd_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_w |-> n_q[0])
    else $error("even harmonic issued");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("product accumulated without a lookup");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> !in_i.ready)
    else $error("input ready while harmonics in flight");

endmodule

>>> hdl/sfs_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on sfs_pkg.
module sfs_mul import sfs_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> tb/tb_square_wave_fourier_synth_unit.sv
`timescale 1ns / 1ps
// Testbench for square_wave_fourier_synth_unit: drives time values, predicts each sample
// from its own sine and coefficient tables, and checks the samples in order.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if and the synthesizer RTL.
module tb_square_wave_fourier_synth_unit;
  import sfs_pkg::*;

  localparam int unsigned SineSize = 1 << SineTableBitsDef;
  localparam int unsigned Quarter = SineSize / 4;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 64;
  localparam int MaxPrints = 40;
  localparam int Phases = 12;
  localparam int PhaseItems = 42;
  localparam longint SampleHi = 64'sd8388607;
  localparam longint SampleLo = -64'sd8388608;

  typedef enum int {FlowFree, FlowSendGaps, FlowRecvStalls, FlowBoth} flow_e;

  typedef struct {
    logic [TimeW-1:0]          t;
    logic signed [SampleW-1:0] sample;
  } sample_expect_t;

  class series_board;
    int             sine_rom[SineSize];
    longint         coef_rom[MaxHarmonicsDef];
    logic [AmpW-1:0]  amp;
    logic [FreqW-1:0] freq;
    logic [LimW-1:0]  lim;
    sample_expect_t expected_samples[$];
    int             mismatches;

    function new();
      longint unsigned x, x2, term;
      longint          acc;
      int unsigned     q, r;
      int              v;
      for (int unsigned k = 0; k < SineSize; k++) begin
        r = k % Quarter;
        q = ((k / Quarter) & 1) ? Quarter - r : r;
        x = (HalfPiQ30 * q + Quarter / 2) / Quarter;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int j = 1; j <= 5; j++) begin
          term = ((term * x2) >> 30) / (2 * j * (2 * j + 1));
          if (j % 2) begin
            acc -= term;
          end else begin
            acc += term;
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        v = int'((acc + 16384) >>> 15);
        sine_rom[k] = ((k / Quarter) & 2) ? -v : v;
      end
      coef_rom[0] = 0;
      for (int unsigned n = 1; n < MaxHarmonicsDef; n++) begin
        coef_rom[n] = (TwoOverPiQ32 + n / 2) / n;
      end
      amp = AmpRst;
      freq = FreqRst;
      lim = LimitRst;
      mismatches = 0;
    endfunction

    function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgAmplitude: amp = data[AmpW-1:0];
        CfgFrequency: freq = data[FreqW-1:0];
        CfgLimit:     lim = data[LimW-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [SampleW-1:0] series_sample(logic [TimeW-1:0] t);
      longint unsigned prod, phase;
      longint          acc, s24, total, smp;
      int unsigned     top;
      prod = 64'(freq) * 64'(t);
      top = (lim > MaxHarmonicsDef) ? MaxHarmonicsDef : lim;
      acc = 0;
      for (int unsigned n = 1; n < top; n += 2) begin
        phase = 64'(prod[31:0]) * 64'(n);
        acc += coef_rom[n] * longint'(sine_rom[phase[31 -: SineTableBitsDef]]);
      end
      s24 = (acc + 64'sd4194304) >>> 23;
      total = (longint'(amp) <<< 23) + longint'(amp) * s24;
      smp = (total + 64'sd8388608) >>> 24;
      if (smp > SampleHi) begin
        smp = SampleHi;
      end
      if (smp < SampleLo) begin
        smp = SampleLo;
      end
      return smp[SampleW-1:0];
    endfunction

    function void note_time(logic [TimeW-1:0] t);
      sample_expect_t e;
      e.t = t;
      e.sample = series_sample(t);
      expected_samples.push_back(e);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MaxPrints) begin
        $display("%0t: %s", $time, msg);
      end
    endtask

    task check_sample(logic signed [SampleW-1:0] got);
      sample_expect_t e;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with no time value waiting", got));
      end else begin
        e = expected_samples.pop_front();
        if (got !== e.sample) begin
          report_mismatch($sformatf("t=%h: sample %0d, expected %0d", e.t, got, e.sample));
        end
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  flow_e              flow = FlowFree;
  int                 idle_cycles = 0;
  series_board        board = new();

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();

  square_wave_fourier_synth_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  always @(negedge clk_i) begin
    out_ch.ready <= !roll(flow == FlowRecvStalls ? 77 : flow == FlowBoth ? 18 : 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_sample(out_ch.sample);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("square_wave_fourier_synth_unit: mismatch");
      $finish;
    end
  end

  task automatic send_time(input logic [TimeW-1:0] t);
    while (roll(flow == FlowSendGaps ? 77 : flow == FlowBoth ? 18 : 0)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.time_value <= t;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    board.note_time(t);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every sample is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.expected_samples.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    board.apply_write(idx, data);
    @(negedge clk_i);
  endtask

  initial begin
    logic [CfgW-1:0]  word;
    logic [TimeW-1:0] t;
    in_ch.valid = 1'b0;
    in_ch.time_value = '0;
    cfg_we = 1'b0;
    cfg_idx = CfgAmplitude;
    cfg_wdata = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_time(32'h0000_0000);
    send_time(32'hFFFF_FFFF);
    send_time(32'h0000_4000);
    send_time(32'h0000_C000);
    send_time(32'h0000_8000);
    send_time(32'h0000_0001);
    write_reg(CfgLimit, 32'd0);
    send_time(32'h0000_4000);
    write_reg(CfgLimit, 32'd1);
    send_time(32'h0000_4000);
    write_reg(CfgLimit, 32'd2);
    send_time(32'h0000_4000);
    write_reg(CfgLimit, 32'd3);
    send_time(32'h0000_4000);
    write_reg(CfgLimit, 32'd64);
    send_time(32'h0000_4000);
    send_time(32'h0000_1234);
    write_reg(CfgLimit, 32'd127);
    send_time(32'h0000_4000);
    write_reg(CfgAmplitude, 32'd0);
    send_time($urandom());
    write_reg(CfgAmplitude, 32'h0000_FFFF);
    send_time(32'h0000_4000);
    send_time(32'h0000_C000);
    write_reg(CfgUnused, 32'h0000_0055);
    send_time(32'h0000_4000);
    write_reg(CfgFrequency, 32'd0);
    send_time(32'hFFFF_FFFF);
    write_reg(CfgFrequency, 32'hFFFF_FFFF);
    send_time(32'hFFFF_FFFF);
    send_time(32'h0000_0001);
    write_reg(CfgAmplitude, 32'hFFFF_0100);
    send_time(32'h0001_8000);

    for (int p = 0; p < Phases; p++) begin
      word = $urandom();
      case ($urandom_range(3))
        0: word[AmpW-1:0] = '0;
        1: word[AmpW-1:0] = '1;
        default: ;
      endcase
      write_reg(CfgAmplitude, word);
      case ($urandom_range(3))
        0: word = '0;
        1: word = '1;
        2: word = $urandom_range(1 << 17);
        default: word = $urandom();
      endcase
      write_reg(CfgFrequency, word);
      word = $urandom();
      case ($urandom_range(3))
        0: word[LimW-1:0] = LimW'($urandom_range(2));
        1: word[LimW-1:0] = LimW'($urandom_range(127, 65));
        default: word[LimW-1:0] = LimW'($urandom_range(64, 3));
      endcase
      write_reg(CfgLimit, word);
      if (p % 3 == 0) begin
        write_reg(CfgUnused, $urandom());
      end
      flow = flow_e'(p % 4);
      for (int i = 0; i < PhaseItems; i++) begin
        t = ($urandom_range(7) == 0) ? $urandom_range(1 << 18) : $urandom();
        send_time(t);
      end
    end

    in_ch.valid <= 1'b0;
    while (board.expected_samples.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (board.mismatches == 0 && board.expected_samples.size() == 0) begin
      $display("square_wave_fourier_synth_unit: match");
    end else begin
      $display("square_wave_fourier_synth_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> square_wave_fourier_synth_unit.f
hdl/sfs_pkg.sv
hdl/sfs_in_if.sv
hdl/sfs_out_if.sv
hdl/sfs_mul.sv
hdl/square_wave_fourier_synth_unit.sv
tb/tb_square_wave_fourier_synth_unit.sv
